// ----- rtl/core/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Command/response payload types, opcode and status codes, default depth.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int SPQ_DEPTH   = 64;
	localparam int SPQ_VALUE_W = 32;
	localparam int SPQ_COUNT_W = 7;

	typedef enum logic {
		ACT_INSERT     = 1'b0,
		ACT_DELETE_MIN = 1'b1
	} spq_action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} spq_status_t;

	// input item
	typedef struct packed {
		spq_action_t                    action;
		logic signed [SPQ_VALUE_W-1:0] value;
	} spq_cmd_t;

	// result item
	typedef struct packed {
		logic signed [SPQ_VALUE_W-1:0] min_value;
		spq_status_t                    status;
		logic [SPQ_COUNT_W-1:0]         count;
	} spq_rsp_t;

	// operation broadcast to every cell in the chain
	typedef struct packed {
		logic                           ins;
		logic                           del;
		logic signed [SPQ_VALUE_W-1:0] value;
	} spq_op_t;

endpackage

// ----- rtl/core/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one value; on insert it keeps, shifts in its left neighbor, or takes
// the new value; on delete-min it shifts in its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell
	import spq_pkg::*;
#(
	parameter int IDX   = 0,
	parameter int CNT_W = 7
) (
	input  logic                          clk,
	input  spq_op_t                       op,
	input  logic [CNT_W-1:0]              cnt,
	input  logic signed [SPQ_VALUE_W-1:0] prev_val,
	input  logic                          prev_gt,
	input  logic signed [SPQ_VALUE_W-1:0] next_val,
	output logic signed [SPQ_VALUE_W-1:0] val,
	output logic                          gt
);

	logic signed [SPQ_VALUE_W-1:0] val_q;
	logic                          occ;

	// an empty slot counts as greater, so the insert point is the first gt cell
	assign occ = cnt > CNT_W'(IDX);
	assign gt  = !occ || (val_q > op.value);
	assign val = val_q;

	// slot update
	always_ff @(posedge clk) begin
		if (op.ins) begin
			if (prev_gt) begin
				val_q <= prev_val;
			end else if (gt) begin
				val_q <= op.value;
			end
		end else if (op.del) begin
			val_q <= next_val;
		end
	end

endmodule

// ----- rtl/core/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded min priority queue, ascending cell chain
// Insert places a value after all stored values <= it; delete-min returns
// and removes the head. One response per command.
// ----------------------------------------------------------------------------
//   channel | dir | handshake            | payload
//   cmd     | in  | cmd_valid/cmd_stall  | spq_cmd_t (action, value)
//   rsp     | out | rsp_valid/rsp_stall  | spq_rsp_t (min_value, status, count)
//
// One command per cycle while cmd_stall is low; each response is registered
// at its transfer. Every cell compares against the new value in parallel
// and moves one step, so each command is a single chain update.
// Reset clears the count and the response buffer; cell contents are not reset.
// A two-entry response buffer lets one more command in while rsp is stalled.
// ----------------------------------------------------------------------------
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH = SPQ_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_stall,
	input  spq_cmd_t cmd,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output spq_rsp_t rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]              cnt_q;
	logic [CNT_W-1:0]              cnt_next;
	logic                          cmd_xfer;
	logic                          rsp_xfer;
	logic                          full;
	logic                          empty;
	spq_op_t                       op;
	spq_rsp_t                      rsp_new;
	spq_rsp_t                      out_q;
	spq_rsp_t                      skid_q;
	logic                          out_valid_q;
	logic                          skid_valid_q;
	logic signed [SPQ_VALUE_W-1:0] cell_val [DEPTH];
	logic                          cell_gt  [DEPTH];

	assign cmd_stall = skid_valid_q;
	assign cmd_xfer  = cmd_valid && !cmd_stall;
	assign rsp_xfer  = out_valid_q && !rsp_stall;
	assign full      = cnt_q == CNT_W'(DEPTH);
	assign empty     = cnt_q == '0;

	// decode command into the chain operation and the response
	always_comb begin
		op.ins   = 1'b0;
		op.del   = 1'b0;
		op.value = cmd.value;
		cnt_next = cnt_q;
		rsp_new.min_value = '0;
		rsp_new.status    = ST_OK;
		case (cmd.action)
			ACT_INSERT: begin
				if (full) begin
					rsp_new.status = ST_FULL;
				end else begin
					op.ins   = cmd_xfer;
					cnt_next = cnt_q + CNT_W'(1);
				end
			end
			ACT_DELETE_MIN: begin
				if (empty) begin
					rsp_new.status = ST_EMPTY;
				end else begin
					op.del   = cmd_xfer;
					cnt_next = cnt_q - CNT_W'(1);
					rsp_new.min_value = cell_val[0];
				end
			end
			default: begin
				rsp_new.status = ST_OK;
			end
		endcase
		rsp_new.count = SPQ_COUNT_W'(cnt_next);
	end

	// the cell chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [SPQ_VALUE_W-1:0] pv;
		logic                          pg;
		logic signed [SPQ_VALUE_W-1:0] nv;
		if (i == 0) begin : g_head
			assign pv = cmd.value;
			assign pg = 1'b0;
		end else begin : g_mid
			assign pv = cell_val[i-1];
			assign pg = cell_gt[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign nv = '0;
		end else begin : g_body
			assign nv = cell_val[i+1];
		end
		spq_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk      (clk),
			.op       (op),
			.cnt      (cnt_q),
			.prev_val (pv),
			.prev_gt  (pg),
			.next_val (nv),
			.val      (cell_val[i]),
			.gt       (cell_gt[i])
		);
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd_xfer) begin
			cnt_q <= cnt_next;
		end
	end

	// response buffer: output register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (rsp_xfer) begin
					skid_valid_q <= 1'b0;
				end
			end else if (cmd_xfer) begin
				if (out_valid_q && !rsp_xfer) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (rsp_xfer) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (rsp_xfer) begin
				out_q <= skid_q;
			end
		end else if (cmd_xfer) begin
			if (out_valid_q && !rsp_xfer) begin
				skid_q <= rsp_new;
			end else begin
				out_q <= rsp_new;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without output entry");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		op.ins |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("insert did not grow the count");

	a_del_count: assert property (@(posedge clk) disable iff (!arst_n)
		op.del |=> cnt_q == $past(cnt_q) - CNT_W'(1))
		else $error("delete-min did not shrink the count");

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking testbench for sorted_priority_queue
// A short directed table runs first: the extremes, equal keys, delete on an
// empty queue and insert after a drain. Random fill, drain and mixed bursts
// follow, and they reach the full queue. A local sorted queue predicts each
// response that the table leaves open. Both channels idle and stall at random,
// and the receiver holds off twice for a long stretch so that backpressure reaches the command side.
// ----------------------------------------------------------------------------
module tb;
	import spq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1225;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 20;

	typedef logic signed [SPQ_VALUE_W-1:0] value_t;

	// directed stimulus row; rsp is used only when typed is set
	typedef struct {
		spq_cmd_t cmd;
		bit       typed;
		spq_rsp_t rsp;
	} probe_row_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     cmd_valid = 1'b0;
	logic     cmd_stall;
	spq_cmd_t cmd       = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	spq_rsp_t rsp;

	value_t     held_values[$];   // predicted queue contents, ascending
	spq_rsp_t   pending_rsp[$];   // responses owed by the block, oldest first
	probe_row_t probe_rows[$];

	int errors    = 0;
	int cycles    = 0;
	int idle_pct  = 7;
	int stall_pct = 51;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;

	sorted_priority_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// cycle watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// sorted queue model: apply one command, return its response
	function automatic spq_rsp_t queue_apply(spq_cmd_t c);
		spq_rsp_t r;
		int pos;
		r = '{min_value: '0, status: ST_OK, count: '0};
		if (c.action == ACT_INSERT) begin
			if (held_values.size() >= SPQ_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				// goes after every stored value <= it
				pos = held_values.size();
				for (int i = 0; i < held_values.size(); i++) begin
					if (held_values[i] > c.value) begin
						pos = i;
						break;
					end
				end
				held_values.insert(pos, c.value);
			end
		end else begin
			if (held_values.size() == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.min_value = held_values.pop_front();
			end
		end
		r.count = SPQ_COUNT_W'(held_values.size());
		return r;
	endfunction

	function automatic void add_row(spq_action_t act, value_t val, bit typed = 1'b0,
			value_t min_v = '0, spq_status_t st = ST_OK, int cnt = 0);
		probe_row_t row;
		row.cmd.action    = act;
		row.cmd.value     = val;
		row.typed         = typed;
		row.rsp.min_value = min_v;
		row.rsp.status    = st;
		row.rsp.count     = SPQ_COUNT_W'(cnt);
		probe_rows.push_back(row);
	endfunction

	// mostly random 32-bit values, some extremes and a small pool for equal keys
	function automatic value_t pick_value();
		case ($urandom_range(15))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2, 3: return value_t'(int'($urandom_range(4)) - 2);
			default: return value_t'($urandom);
		endcase
	endfunction

	function automatic void check_rsp(spq_rsp_t got);
		spq_rsp_t want;
		if (pending_rsp.size() == 0) begin
			$display("%0t: response with none pending: min %0d status %0d count %0d",
				$time, got.min_value, got.status, got.count);
			errors++;
			return;
		end
		want = pending_rsp.pop_front();
		if (got.min_value !== want.min_value) begin
			$display("%0t: min_value expected %0d, actual %0d",
				$time, want.min_value, got.min_value);
			errors++;
		end
		if (got.status !== want.status) begin
			$display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
			errors++;
		end
		if (got.count !== want.count) begin
			$display("%0t: count expected %0d, actual %0d", $time, want.count, got.count);
			errors++;
		end
	endfunction

	// response side: check each transfer, then choose the next stall
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			check_rsp(rsp);
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// offer one command after a random gap; wait for its transfer
	task automatic send_cmd(spq_cmd_t c, bit typed = 1'b0, spq_rsp_t fixed = '0);
		spq_rsp_t model;
		if ($urandom_range(99) < idle_pct) begin
			cmd_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (cmd_stall);
		model = queue_apply(c);
		pending_rsp.push_back(typed ? fixed : model);
	endtask

	task automatic drain_wait();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending_rsp.size() != 0);
	endtask

	initial begin
		spq_cmd_t c;
		int burst_left;
		int ins_pct;

		// extremes, empty delete, equal keys, insert after drain
		add_row(ACT_DELETE_MIN, 32'sd0, 1'b1, 32'sd0, ST_EMPTY, 0);
		add_row(ACT_INSERT, 32'sh7fffffff, 1'b1, 32'sd0, ST_OK, 1);
		add_row(ACT_INSERT, 32'sh80000000, 1'b1, 32'sd0, ST_OK, 2);
		add_row(ACT_DELETE_MIN, 32'sd0, 1'b1, 32'sh80000000, ST_OK, 1);
		add_row(ACT_DELETE_MIN, 32'sd0, 1'b1, 32'sh7fffffff, ST_OK, 0);
		add_row(ACT_DELETE_MIN, 32'sh7fffffff, 1'b1, 32'sd0, ST_EMPTY, 0);
		add_row(ACT_INSERT, 32'sd5);
		add_row(ACT_INSERT, 32'sd5);
		add_row(ACT_INSERT, -32'sd1);
		add_row(ACT_INSERT, 32'sd0);
		add_row(ACT_INSERT, 32'sh7fffffff);
		add_row(ACT_INSERT, 32'sh7fffffff);
		add_row(ACT_INSERT, 32'sd3);
		add_row(ACT_DELETE_MIN, 32'sd0);
		add_row(ACT_DELETE_MIN, 32'shffffffff);
		repeat (5) add_row(ACT_DELETE_MIN, 32'sd0);
		add_row(ACT_DELETE_MIN, 32'sd0, 1'b1, 32'sd0, ST_EMPTY, 0);
		add_row(ACT_INSERT, 32'sd1, 1'b1, 32'sd0, ST_OK, 1);
		add_row(ACT_DELETE_MIN, 32'sd0, 1'b1, 32'sd1, ST_OK, 0);

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		foreach (probe_rows[i])
			send_cmd(probe_rows[i].cmd, probe_rows[i].typed, probe_rows[i].rsp);

		// random bursts biased toward fill, drain or a mix
		burst_left = 0;
		ins_pct    = 50;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3) begin
				drain_wait();
				idle_pct  = 51;
				stall_pct = 7;
			end else if (n == 2 * RANDOM_ITEMS / 3) begin
				drain_wait();
				idle_pct  = 0;
				stall_pct = 0;
			end
			// long receiver hold-off while commands keep coming
			if (n == 100 || n == 2 * RANDOM_ITEMS / 3 + 60)
				hold_reqs++;
			if (burst_left == 0) begin
				burst_left = $urandom_range(90, 20);
				case ($urandom_range(2))
					0: ins_pct = 85;
					1: ins_pct = 15;
					default: ins_pct = 50;
				endcase
			end
			burst_left--;
			c.action = ($urandom_range(99) < ins_pct) ? ACT_INSERT : ACT_DELETE_MIN;
			c.value  = pick_value();
			send_cmd(c);
		end

		drain_wait();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- sorted_priority_queue.f -----
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue.sv
test/tb.sv
